[hdl/efa_pkg.sv]
// Package for the elementwise activation / FMA ALU: data widths, operation codes,
// register indexes and fixed-point constants.
// No dependencies.
package efa_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int FRAC_BITS       = 16;
	localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
	localparam int RES_WIDTH       = 2 * DATA_WIDTH + 2;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef logic signed [DATA_WIDTH-1:0]   data_t;
	typedef logic signed [DATA_WIDTH+1:0]   ext_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [RES_WIDTH-1:0]    res_t;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SCALE  = 3'd1,
		OP_MUL    = 3'd2,
		OP_FMA    = 3'd3,
		OP_RELU   = 3'd4,
		OP_CLIP   = 3'd5,
		OP_HSWISH = 3'd6
	} op_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_SCALE = 2'd0,
		CFG_CLIP  = 2'd1
	} cfg_idx_t;

	// rounding constant, one half LSB of the fraction
	localparam res_t HALF = {{(RES_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam res_t THREE = RES_WIDTH'(longint'(3) <<< FRAC_BITS);
	localparam longint SIXTH_L = ((longint'(1) <<< FRAC_BITS) + 3) / 6;
	localparam data_t SIXTH = DATA_WIDTH'(SIXTH_L);

	localparam res_t DMAX = {{(RES_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam res_t DMIN = {{(RES_WIDTH-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

	localparam longint DMAX_L  = (longint'(1) <<< (DATA_WIDTH-1)) - 1;
	localparam longint ONE_L   = longint'(1) <<< FRAC_BITS;
	localparam longint SIX_L   = longint'(6) <<< FRAC_BITS;
	localparam data_t  SCALE_RESET = DATA_WIDTH'((ONE_L > DMAX_L) ? DMAX_L : ONE_L);
	localparam data_t  CLIP_RESET  = DATA_WIDTH'((SIX_L > DMAX_L) ? DMAX_L : SIX_L);

endpackage

[hdl/elementwise_activation_fma_alu.sv]
// Elementwise activation / FMA ALU top level: six-stage pipeline with config registers.
// Depends on efa_pkg.
//
// One element enters per clock on start and its result leaves the last stage, s6,
// with done high for one cycle; there is no backpressure, so busy is always
// low and a new request may be issued every cycle. After the decode stage, the depth is set by the
// two dependent multiplies of hard-swish (a times one sixth, then times max(a+3,0)),
// each followed by its rounding stage, plus a final saturation stage. The config
// channel is always ready; write it only while no request is in flight. Indexes
// other than the two defined registers are ignored.
module elementwise_activation_fma_alu
	import efa_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 operation,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	input  logic signed [DATA_WIDTH-1:0] accumulator,
	input  logic                       last,
	output logic                       done,
	output logic signed [DATA_WIDTH-1:0] value_out,
	output logic                       saturated,
	output logic                       last_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic signed [DATA_WIDTH-1:0] cfg_data
);

	data_t scale_q, clip_q;

	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, done_s6;
	op_t   op_s1, op_s2, op_s3, op_s4;
	logic  last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	data_t a_s1, a_s2, a_s3;
	data_t b_s1, b_s2, b_s3;
	data_t acc_s1, acc_s2, acc_s3;
	ext_t  m_s1, m_s2, m_s3;
	prod_t p1_s2;
	res_t  r1_s3;
	res_t  p2_s4, other_s4, amax3_s4;
	res_t  r_s5;
	data_t value_s6;
	logic  sat_s6;

	op_t   op_in;
	data_t mul_op;
	res_t  a_plus3;
	ext_t  m_in;
	data_t a6;
	data_t relu_a;
	res_t  other;
	res_t  hs;
	res_t  hs_fin;
	res_t  r_fin;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			clip_q  <= CLIP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SCALE) begin
				scale_q <= cfg_data;
			end else if (cfg_index == CFG_CLIP) begin
				clip_q <= cfg_data;
			end
		end
	end

	// stage 1 decode
	always_comb begin
		op_in   = op_t'(operation);
		a_plus3 = res_t'(operand_a) + THREE;
		m_in    = (a_plus3 < 0) ? '0 : a_plus3[DATA_WIDTH+1:0];
		unique case (op_in)
			OP_SCALE:  mul_op = scale_q;
			OP_HSWISH: mul_op = SIXTH;
			default:   mul_op = operand_b;
		endcase
	end

	// stage 4 second product operand and non-hswish results
	always_comb begin
		a6     = r1_s3[DATA_WIDTH-1:0];
		relu_a = (a_s3 < 0) ? '0 : a_s3;
		unique case (op_s3)
			OP_ADD:          other = res_t'(a_s3) + res_t'(b_s3);
			OP_SCALE, OP_MUL: other = r1_s3;
			OP_FMA:          other = r1_s3 + res_t'(acc_s3);
			OP_RELU:         other = res_t'(relu_a);
			OP_CLIP:         other = res_t'((relu_a < clip_q) ? relu_a : clip_q);
			default:         other = '0;
		endcase
	end

	// stage 5 hswish finish
	always_comb begin
		hs     = (p2_s4 + HALF) >>> FRAC_BITS;
		hs_fin = (amax3_s4 < hs) ? amax3_s4 : hs;
		r_fin  = (op_s4 == OP_HSWISH) ? hs_fin : other_s4;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			done_s6 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			done_s6 <= vld_s5;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		op_s1   <= op_in;
		last_s1 <= last;
		a_s1    <= operand_a;
		b_s1    <= mul_op;
		acc_s1  <= accumulator;
		m_s1    <= m_in;

		op_s2   <= op_s1;
		last_s2 <= last_s1;
		a_s2    <= a_s1;
		b_s2    <= b_s1;
		acc_s2  <= acc_s1;
		m_s2    <= m_s1;
		p1_s2   <= a_s1 * b_s1;

		op_s3   <= op_s2;
		last_s3 <= last_s2;
		a_s3    <= a_s2;
		b_s3    <= b_s2;
		acc_s3  <= acc_s2;
		m_s3    <= m_s2;
		r1_s3   <= (res_t'(p1_s2) + HALF) >>> FRAC_BITS;

		op_s4    <= op_s3;
		last_s4  <= last_s3;
		p2_s4    <= a6 * m_s3;
		other_s4 <= other;
		amax3_s4 <= (res_t'(a_s3) < THREE) ? THREE : res_t'(a_s3);

		last_s5 <= last_s4;
		r_s5    <= r_fin;

		last_s6 <= last_s5;
		if (r_s5 > DMAX) begin
			value_s6 <= DMAX[DATA_WIDTH-1:0];
			sat_s6   <= 1'b1;
		end else if (r_s5 < DMIN) begin
			value_s6 <= DMIN[DATA_WIDTH-1:0];
			sat_s6   <= 1'b1;
		end else begin
			value_s6 <= r_s5[DATA_WIDTH-1:0];
			sat_s6   <= 1'b0;
		end
	end

	assign done      = done_s6;
	assign value_out = value_s6;
	assign saturated = sat_s6;
	assign last_out  = last_s6;

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("request did not complete after six cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##6 !done)
		else $error("result without request");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(value_out == DMAX[DATA_WIDTH-1:0] || value_out == DMIN[DATA_WIDTH-1:0]))
		else $error("saturated result not at a range limit");

endmodule

[tb/efa_checker.sv]
// Scoreboard for the elementwise activation / FMA ALU: predicts each element from the
// request channel and the register writes, and compares every done strobe in order.
// Depends on efa_pkg.
module efa_checker
	import efa_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [2:0]                 operation,
	input  data_t                      operand_a,
	input  data_t                      operand_b,
	input  data_t                      accumulator,
	input  logic                       last,
	input  logic                       done,
	input  data_t                      value_out,
	input  logic                       saturated,
	input  logic                       last_out,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  data_t                      cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		data_t value;
		logic  sat;
		logic  last;
	} elem_t;

	localparam data_t SCALE_AT_RESET = data_t'(longint'(1) <<< FRAC_BITS);
	localparam data_t CLIP_AT_RESET  = data_t'(longint'(6) <<< FRAC_BITS);

	elem_t due_results[$];
	data_t scale_reg = SCALE_AT_RESET;
	data_t clip_reg  = CLIP_AT_RESET;

	function automatic wide_t round_mul(wide_t x, wide_t y);
		wide_t half;
		half = wide_t'(1) <<< (FRAC_BITS - 1);
		return (x * y + half) >>> FRAC_BITS;
	endfunction

	function automatic elem_t element_result(logic [2:0] op, data_t a_in, data_t b_in,
			data_t acc_in, logic lst, data_t scale, data_t clip);
		wide_t a, b, acc, sw, cw, three, sixth, hi, lo, r, a6, m, floor3;
		elem_t e;
		a      = a_in;
		b      = b_in;
		acc    = acc_in;
		sw     = scale;
		cw     = clip;
		three  = wide_t'(3) <<< FRAC_BITS;
		sixth  = ((wide_t'(1) <<< FRAC_BITS) + 3) / 6;
		hi     = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
		lo     = -(wide_t'(1) <<< (DATA_WIDTH - 1));
		r      = 0;
		case (op)
			OP_ADD:    r = a + b;
			OP_SCALE:  r = round_mul(a, sw);
			OP_MUL:    r = round_mul(a, b);
			OP_FMA:    r = round_mul(a, b) + acc;
			OP_RELU:   r = (a > 0) ? a : 0;
			OP_CLIP: begin
				r = (a > 0) ? a : 0;
				if (cw < r)
					r = cw;
			end
			OP_HSWISH: begin
				a6 = round_mul(a, sixth);
				m = a + three;
				if (m < 0)
					m = 0;
				r = round_mul(a6, m);
				floor3 = (a > three) ? a : three;
				if (floor3 < r)
					r = floor3;
			end
			default:   r = 0;
		endcase
		e.sat = (r > hi) || (r < lo);
		if (r > hi)
			e.value = data_t'(hi);
		else if (r < lo)
			e.value = data_t'(lo);
		else
			e.value = data_t'(r);
		e.last = lst;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		elem_t exp_e;
		if (!arst_n) begin
			scale_reg = SCALE_AT_RESET;
			clip_reg = CLIP_AT_RESET;
			due_results.delete();
		end else begin
			if (start && !busy)
				due_results.push_back(element_result(operation, operand_a, operand_b,
					accumulator, last, scale_reg, clip_reg));
			if (done) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected: value %h sat %b last %b",
						$time, value_out, saturated, last_out);
				end else begin
					exp_e = due_results.pop_front();
					checked++;
					if (value_out !== exp_e.value) begin
						fail_count++;
						$display("%0t: value_out expected %h, actual %h",
							$time, exp_e.value, value_out);
					end
					if (saturated !== exp_e.sat) begin
						fail_count++;
						$display("%0t: saturated expected %b, actual %b",
							$time, exp_e.sat, saturated);
					end
					if (last_out !== exp_e.last) begin
						fail_count++;
						$display("%0t: last_out expected %b, actual %b",
							$time, exp_e.last, last_out);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCALE: scale_reg = cfg_data;
					CFG_CLIP:  clip_reg = cfg_data;
					default:   ;
				endcase
			end
		end
		pending = due_results.size();
	end

endmodule

[tb/tb.sv]
// Testbench top for the elementwise activation / FMA ALU: directed corner requests,
// then randomized phases under several register settings, checked by efa_checker.
// Depends on efa_pkg, elementwise_activation_fma_alu and efa_checker.
module tb;
	import efa_pkg::*;

	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;
	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam data_t ONE = data_t'(longint'(1) <<< FRAC_BITS);
	localparam int PHASES = 6;
	localparam int PHASE_LEN = 292;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [2:0]                 operation;
	data_t                      operand_a;
	data_t                      operand_b;
	data_t                      accumulator;
	logic                       last;
	logic                       done;
	data_t                      value_out;
	logic                       saturated;
	logic                       last_out;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	data_t                      cfg_data;
	int                         fail_count;
	int                         pending;
	int                         checked;
	bit                         idling;

	elementwise_activation_fma_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.accumulator(accumulator), .last(last), .done(done), .value_out(value_out),
		.saturated(saturated), .last_out(last_out), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	efa_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.accumulator(accumulator), .last(last), .done(done), .value_out(value_out),
		.saturated(saturated), .last_out(last_out), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("%0t: timeout with %0d results outstanding", $time, pending);
		$display("tb failed");
		$finish;
	end

	function automatic data_t rand_operand();
		case ($urandom_range(9))
			0:       return DATA_MAX;
			1:       return DATA_MIN;
			2:       return '0;
			3, 4, 5: return data_t'($urandom);
			default: return data_t'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic data_t rand_small();
		return data_t'(int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	// start stays high across back-to-back requests; lowered only for idle cycles
	task automatic send_elem(logic [2:0] op, data_t a, data_t b, data_t acc, logic lst);
		while (idling && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		accumulator <= acc;
		last <= lst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [2:0] op;
		op = ($urandom_range(39) == 0) ? OP_SPARE : 3'($urandom_range(6));
		send_elem(op, rand_operand(), rand_operand(), rand_operand(), 1'($urandom_range(1)));
	endtask

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, data_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic load_regs(data_t scale, data_t clip);
		write_reg(CFG_SPARE_LO, data_t'($urandom));
		write_reg(CFG_SCALE, scale);
		write_reg(CFG_SPARE_HI, data_t'($urandom));
		write_reg(CFG_CLIP, clip);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		data_t scale_set[PHASES];
		data_t clip_set[PHASES];
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		operand_a = '0;
		operand_b = '0;
		accumulator = '0;
		last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SCALE;
		cfg_data = '0;
		idling = 1'b1;
		scale_set = '{DATA_MAX, DATA_MIN, '0, -ONE, rand_small(), rand_small()};
		clip_set = '{DATA_MAX, DATA_MIN, '0, -(2 * ONE), rand_small(), rand_small()};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at reset register values
		send_elem(OP_ADD, DATA_MAX, DATA_MAX, '0, 1'b0);
		send_elem(OP_ADD, DATA_MIN, DATA_MIN, DATA_MAX, 1'b1);
		send_elem(OP_ADD, DATA_MAX, '0, DATA_MIN, 1'b0);
		send_elem(OP_SCALE, DATA_MAX, DATA_MIN, '0, 1'b0);
		send_elem(OP_SCALE, DATA_MIN, '0, '0, 1'b1);
		send_elem(OP_MUL, DATA_MAX, DATA_MAX, '0, 1'b0);
		send_elem(OP_MUL, DATA_MIN, DATA_MIN, '0, 1'b0);
		send_elem(OP_MUL, DATA_MIN, DATA_MAX, '0, 1'b0);
		send_elem(OP_MUL, 32'sd1, 32'sh0000_8000, '0, 1'b0);
		send_elem(OP_MUL, -32'sd1, 32'sh0000_8000, '0, 1'b0);
		// product just past the top, pulled back in by the accumulator
		send_elem(OP_FMA, 32'sh0080_0000, 32'sh0100_0000, -32'sd1, 1'b0);
		send_elem(OP_FMA, DATA_MIN, DATA_MIN, DATA_MIN, 1'b1);
		send_elem(OP_RELU, DATA_MIN, '0, '0, 1'b0);
		send_elem(OP_RELU, DATA_MAX, '0, '0, 1'b0);
		send_elem(OP_CLIP, DATA_MAX, '0, '0, 1'b0);
		send_elem(OP_CLIP, -(5 * ONE), '0, '0, 1'b0);
		send_elem(OP_HSWISH, DATA_MIN, '0, '0, 1'b0);
		send_elem(OP_HSWISH, DATA_MAX, '0, '0, 1'b0);
		send_elem(OP_HSWISH, -(3 * ONE), '0, '0, 1'b0);
		send_elem(OP_HSWISH, 3 * ONE, '0, '0, 1'b0);
		send_elem(OP_HSWISH, ONE, '0, '0, 1'b0);
		send_elem(OP_SPARE, DATA_MAX, DATA_MIN, DATA_MAX, 1'b1);

		// spare register indexes must leave both registers alone
		settle();
		write_reg(CFG_SPARE_LO, DATA_MIN);
		write_reg(CFG_SPARE_HI, DATA_MAX);
		cfg_valid <= 1'b0;
		send_elem(OP_SCALE, 3 * ONE, '0, '0, 1'b0);
		send_elem(OP_CLIP, DATA_MAX, '0, '0, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			load_regs(scale_set[p], clip_set[p]);
			idling = (p != 2);
			repeat (PHASE_LEN) send_random();
		end

		settle();
		repeat (8) @(posedge clk);
		$display("%0d results checked over %0d register settings plus reset values,", checked,
			PHASES);
		$display("covering all seven operations, the spare opcode and spare register writes");
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

[sim.f]
hdl/efa_pkg.sv
hdl/elementwise_activation_fma_alu.sv
tb/efa_checker.sv
tb/tb.sv
